// File: rtl/dss_pkg.sv
// Shared constants and types for the deadline slot scheduler.
// No dependencies; imported by dss_cell and deadline_slot_scheduler_unit.
package dss_pkg;

    // Slot table size and how it splits into cells of eight slots
    localparam int SLOT_COUNT = 64;
    localparam int CELL_W     = 8;
    localparam int LOCAL_W    = 3;
    localparam int CELL_COUNT = (SLOT_COUNT + CELL_W - 1) / CELL_W;
    localparam int CELL_IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SLOT_W     = CELL_IDX_W + LOCAL_W;
    localparam int LIM_W      = SLOT_W + 1;

    // Word field widths
    localparam int ID_W     = 16;
    localparam int DL_W     = 16;
    localparam int PROFIT_W = 32;
    localparam int TOTAL_W  = 48;
    localparam int OUT_SLOT_W = 6;

    // Search wave handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } wave_t;

endpackage

// File: rtl/dss_cell.sv
// One cell of the slot row: holds eight busy bits and claims the latest
// eligible free slot as the search wave passes. Depends on dss_pkg.
module dss_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [dss_pkg::CELL_IDX_W-1:0]  cell_idx,
    input  logic                            clear,
    input  logic [dss_pkg::LIM_W-1:0]       lim,
    input  dss_pkg::wave_t                  wave_in,
    output dss_pkg::wave_t                  wave_out
);
    import dss_pkg::*;

    logic [CELL_W-1:0]  busy_reg;
    logic [CELL_W-1:0]  busy_next;
    logic [CELL_W-1:0]  eligible;
    logic               hit;
    logic [LOCAL_W-1:0] sel;
    logic               claim;
    wave_t              wave_reg;
    wave_t              wave_next;

    // Eligible: free and below the clipped deadline
    always_comb
    begin
        for (int i = 0; i < CELL_W; i++)
        begin
            eligible[i] = !busy_reg[i] &&
                ({1'b0, cell_idx, LOCAL_W'(i)} < lim);
        end
    end

    // Highest eligible slot in this cell
    always_comb
    begin
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < CELL_W; i++)
        begin
            if (eligible[i])
            begin
                hit = 1'b1;
                sel = LOCAL_W'(i);
            end
        end
    end

    assign claim = wave_in.valid && !wave_in.found && hit;

    // Busy bits and outgoing wave
    always_comb
    begin
        busy_next = busy_reg;
        if (clear)
        begin
            busy_next = '0;
        end
        else if (claim)
        begin
            busy_next[sel] = 1'b1;
        end
        wave_next = wave_in;
        if (claim)
        begin
            wave_next.found = 1'b1;
            wave_next.slot  = {cell_idx, sel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            wave_reg.valid <= 1'b0;
            wave_reg.found <= 1'b0;
            wave_reg.slot  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

// File: rtl/deadline_slot_scheduler_unit.sv
// Top level of the deadline slot scheduler: job sequencer, row of slot
// cells and result register. Depends on dss_pkg and dss_cell.
//
// Usage: jobs come in on in_valid/in_ready, sorted by falling profit; each
// input word yields exactly one result word on out_valid/out_ready. A word
// with start_set high clears every slot and the running total first.
// An accepted job launches a search wave that walks the cell row,
// one cell of eight slots per cycle, from the highest slots down; the first
// cell holding a free slot below the clipped deadline claims its highest
// one. The wave passes the launch register, then each cell, then the park
// register, and the result is loaded into the output register from there.
// One job is in flight at a time, so a new job is taken only after the
// result of the last one has moved into the output register.
// in_ready is high whenever no job is in flight, also while a result waits
// to be taken. If the receiver stalls, the finished search is parked and
// in_ready stays low until the waiting result is taken and the parked one
// moves into the output register. Reset frees all slots, zeroes the total
// and empties the pipeline.
module deadline_slot_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           start_set,
    input  logic [dss_pkg::ID_W-1:0]       job_id,
    input  logic [dss_pkg::DL_W-1:0]       deadline,
    input  logic [dss_pkg::PROFIT_W-1:0]   profit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dss_pkg::ID_W-1:0]       out_job_id,
    output logic [dss_pkg::DL_W-1:0]       out_deadline,
    output logic [dss_pkg::PROFIT_W-1:0]   out_profit,
    output logic                           placed,
    output logic [dss_pkg::OUT_SLOT_W-1:0] slot_index,
    output logic [dss_pkg::TOTAL_W-1:0]    total_profit
);
    import dss_pkg::*;

    logic                  in_accept;
    logic                  load;
    logic                  busy_reg;
    logic                  pend_valid_reg;
    logic                  pend_found_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic [ID_W-1:0]       id_reg;
    logic [DL_W-1:0]       dl_reg;
    logic [PROFIT_W-1:0]   profit_reg;
    logic [LIM_W-1:0]      lim_reg;
    logic [LIM_W-1:0]      lim_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic [TOTAL_W:0]      sum;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_wide;
    logic                  out_valid_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic [DL_W-1:0]       out_dl_reg;
    logic [PROFIT_W-1:0]   out_profit_reg;
    logic                  out_placed_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic                  clear;
    wave_t                 launch_reg;
    wave_t                 chain [CELL_COUNT+1];
    logic [CELL_COUNT:0]   wave_vld;

    assign in_ready  = !busy_reg;
    assign in_accept = in_valid && !busy_reg;
    assign load      = pend_valid_reg && (!out_valid_reg || out_ready);
    assign clear     = in_accept && start_set;

    // Clip deadline to the slot count
    always_comb
    begin
        if (deadline > DL_W'(SLOT_COUNT))
        begin
            lim_next = LIM_W'(SLOT_COUNT);
        end
        else
        begin
            lim_next = deadline[LIM_W-1:0];
        end
    end

    // Saturating running total
    assign sum = {1'b0, total_reg} + {{(TOTAL_W+1-PROFIT_W){1'b0}}, profit_reg};
    always_comb
    begin
        total_next = total_reg;
        if (pend_found_reg)
        begin
            total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        end
    end

    assign slot_wide = {{OUT_SLOT_W{1'b0}}, pend_slot_reg};

    // Job registers, loaded at accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg     <= job_id;
            dl_reg     <= deadline;
            profit_reg <= profit;
            lim_reg    <= lim_next;
        end
    end

    // Sequencer: launch, park the finished search, hand to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_found_reg   <= 1'b0;
            pend_slot_reg    <= '0;
            total_reg        <= '0;
            launch_reg.valid <= 1'b0;
            launch_reg.found <= 1'b0;
            launch_reg.slot  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            launch_reg.valid <= in_accept;
            launch_reg.found <= 1'b0;
            launch_reg.slot  <= '0;
            if (in_accept)
            begin
                busy_reg <= 1'b1;
                if (start_set)
                begin
                    total_reg <= '0;
                end
            end
            if (chain[0].valid)
            begin
                pend_valid_reg <= 1'b1;
                pend_found_reg <= chain[0].found;
                pend_slot_reg  <= chain[0].slot;
            end
            if (load)
            begin
                pend_valid_reg <= 1'b0;
                busy_reg       <= 1'b0;
                total_reg      <= total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_id_reg     <= id_reg;
            out_dl_reg     <= dl_reg;
            out_profit_reg <= profit_reg;
            out_placed_reg <= pend_found_reg;
            out_slot_reg   <= pend_found_reg ? slot_wide[OUT_SLOT_W-1:0] : '0;
            out_total_reg  <= total_next;
        end
    end

    // Row of slot cells, wave runs from the top cell to cell 0
    assign chain[CELL_COUNT] = launch_reg;

    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        dss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (CELL_IDX_W'(k)),
            .clear    (clear),
            .lim      (lim_reg),
            .wave_in  (chain[k+1]),
            .wave_out (chain[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k <= CELL_COUNT; k++)
        begin
            wave_vld[k] = chain[k].valid;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_job_id   = out_id_reg;
    assign out_deadline = out_dl_reg;
    assign out_profit   = out_profit_reg;
    assign placed       = out_placed_reg;
    assign slot_index   = out_slot_reg;
    assign total_profit = out_total_reg;

    // At most one search wave in the row
    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wave_vld))
        else $error("more than one search wave in flight");

    // A wave only runs while a job is in flight and nothing is parked
    a_wave_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wave_vld != '0 |-> busy_reg && !pend_valid_reg)
        else $error("search wave without a job in flight");

    // A found slot lies below the clipped deadline
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && pend_found_reg |-> {1'b0, pend_slot_reg} < lim_reg)
        else $error("claimed slot beyond deadline");

    // Loading the output frees the sequencer and shows a word
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && !busy_reg)
        else $error("result load did not complete");

endmodule
